// File: sv/assert_macros.svh
// Assertion macros for the RTL files.
// No dependencies; expects clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/blpt_pkg.sv
// Shared types and constants of the byte lifting pyramid transform.
// No dependencies.
package blpt_pkg;

	localparam int DATA_W = 8;
	localparam int CFG_W  = 7;

	// configuration register indexes
	localparam logic REG_DIRECTION = 1'b0;
	localparam logic REG_LENGTH    = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_COMP = 4'b0010,
		S_COPY = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		OP_PASS = 2'd0,
		OP_SUB  = 2'd1,
		OP_ADD  = 2'd2
	} op_t;

endpackage

// File: sv/byte_lifting_pyramid_transform.sv
// Byte lifting pyramid transform: loads one byte per accepted request, L = ceil(log2 len)
// levels, each n_k = ceil(len/2^k) entries into scratch plus n_k entries of copy-back, then
// len output reads, first result in the cycle after its read. The run time is set by the
// single write port of each memory. Output cannot be stalled.
// Reset (arst_n low) clears control and config; stores undefined.
// Depends on blpt_pkg, blpt_ram and assert_macros.svh.
`include "assert_macros.svh"

module byte_lifting_pyramid_transform
	import blpt_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              start,
	output logic              busy,
	input  logic [DATA_W-1:0] sample,
	// result channel
	output logic              strobe,
	output logic [DATA_W-1:0] value,
	output logic              last,
	// configuration write port
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [CFG_W-1:0]  wr_data
);

	localparam int AW     = $clog2(MAX_LEN);
	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int SW     = LEN_W + 1;
	localparam int LEVELS = $clog2(MAX_LEN);
	localparam int KW     = $clog2(LEVELS + 1);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic             dir_q;
	logic [CFG_W-1:0] len_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q     <= 1'b0;
			len_cfg_q <= CFG_W'(64);
		end else if (wr_en) begin
			case (wr_index)
				REG_DIRECTION: dir_q     <= wr_data[0];
				REG_LENGTH:    len_cfg_q <= wr_data;
				default:       ;
			endcase
		end
	end

	// Effective length: zero acts as one, oversize clamps to MAX_LEN.
	logic [LEN_W-1:0] eff_len;
	always_comb begin
		if (len_cfg_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (len_cfg_q > CFG_W'(MAX_LEN)) begin
			eff_len = LEN_W'(MAX_LEN);
		end else begin
			eff_len = LEN_W'(len_cfg_q);
		end
	end

	// Number of levels: ceil(log2(len)), i.e. bit length of len-1.
	logic [LEN_W-1:0] len_m1;
	logic [KW-1:0]    num_levels;
	always_comb begin
		len_m1     = eff_len - LEN_W'(1);
		num_levels = '0;
		for (int b = 0; b < LEN_W; b++) begin
			if (len_m1[b]) begin
				num_levels = KW'(b + 1);
			end
		end
	end

	// Size of level k: ceil(len / 2^k).
	function automatic logic [LEN_W-1:0] level_size(input logic [LEN_W-1:0] len,
			input logic [KW-1:0] k);
		logic [SW-1:0] t;
		t = {1'b0, len} + ((SW'(1) << k) - SW'(1));
		return LEN_W'(t >> k);
	endfunction

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	state_t           state_q;
	logic [LEN_W-1:0] cnt_q;    // bytes loaded so far
	logic [LEN_W-1:0] j_q;      // issue index within the current pass
	logic [LEN_W-1:0] n_q;      // entries in the current pass
	logic [KW-1:0]    lvl_q;    // current level, 0 is the full block

	logic             accept;
	logic             complete;
	logic             pass_end;
	logic [LEN_W-1:0] half_up;  // ceil(n/2), start of the detail half

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign complete = ({1'b0, cnt_q} + SW'(1)) >= {1'b0, eff_len};
	assign pass_end = (j_q == n_q - LEN_W'(1));
	assign half_up  = LEN_W'(({1'b0, n_q} + SW'(1)) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			j_q     <= '0;
			n_q     <= '0;
			lvl_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						j_q <= '0;
						if (complete) begin
							cnt_q <= '0;
							if (num_levels == '0) begin
								// single byte: nothing to transform
								n_q     <= eff_len;
								state_q <= S_OUT;
							end else if (dir_q) begin
								lvl_q   <= num_levels - KW'(1);
								n_q     <= level_size(eff_len, num_levels - KW'(1));
								state_q <= S_COMP;
							end else begin
								lvl_q   <= '0;
								n_q     <= eff_len;
								state_q <= S_COMP;
							end
						end else begin
							cnt_q <= cnt_q + LEN_W'(1);
						end
					end
				end
				S_COMP: begin
					if (pass_end) begin
						j_q     <= '0;
						state_q <= S_COPY;
					end else begin
						j_q <= j_q + LEN_W'(1);
					end
				end
				S_COPY: begin
					if (pass_end) begin
						j_q <= '0;
						if (!dir_q && (lvl_q + KW'(1) < num_levels)) begin
							// forward: next, smaller level
							lvl_q   <= lvl_q + KW'(1);
							n_q     <= level_size(eff_len, lvl_q + KW'(1));
							state_q <= S_COMP;
						end else if (dir_q && (lvl_q != '0)) begin
							// inverse: next, larger level
							lvl_q   <= lvl_q - KW'(1);
							n_q     <= level_size(eff_len, lvl_q - KW'(1));
							state_q <= S_COMP;
						end else begin
							n_q     <= eff_len;
							state_q <= S_OUT;
						end
					end else begin
						j_q <= j_q + LEN_W'(1);
					end
				end
				S_OUT: begin
					if (pass_end) begin
						state_q <= S_IDLE;
					end else begin
						j_q <= j_q + LEN_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Lifting address generation for one destination entry j
	//   forward: j <  h : block[2j]
	//            j >= h : block[2k+1] - block[2k], k = j - h
	//   inverse: j even : block[j/2]  (covers the odd tail)
	//            j odd  : block[j/2] + block[j/2 + h]
	// ------------------------------------------------------------------
	logic [SW-1:0] addr_a;
	logic [SW-1:0] addr_b;
	op_t           op;

	always_comb begin
		if (dir_q) begin
			addr_a = SW'(j_q >> 1);
			addr_b = SW'(j_q >> 1) + SW'(half_up);
			op     = j_q[0] ? OP_ADD : OP_PASS;
		end else if (j_q < half_up) begin
			addr_a = {j_q, 1'b0};
			addr_b = {j_q, 1'b0} + SW'(1);
			op     = OP_PASS;
		end else begin
			addr_a = {j_q - half_up, 1'b0};
			addr_b = {j_q - half_up, 1'b0} + SW'(1);
			op     = OP_SUB;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: memory data arrives, result written or emitted
	// ------------------------------------------------------------------
	logic             comp_s1;
	logic             copy_s1;
	logic             out_s1;
	logic             last_s1;
	op_t              op_s1;
	logic [AW-1:0]    dst_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_s1 <= 1'b0;
			copy_s1 <= 1'b0;
			out_s1  <= 1'b0;
		end else begin
			comp_s1 <= (state_q == S_COMP);
			copy_s1 <= (state_q == S_COPY);
			out_s1  <= (state_q == S_OUT);
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= op;
		dst_s1  <= j_q[AW-1:0];
		last_s1 <= pass_end;
	end

	// ------------------------------------------------------------------
	// Memories. Each pass reads one store and writes the other, so the
	// registered write never meets a read of the same entry.
	// ------------------------------------------------------------------
	logic              blk_we;
	logic [AW-1:0]     blk_wa;
	logic [DATA_W-1:0] blk_wd;
	logic [AW-1:0]     blk_ra_a;
	logic [DATA_W-1:0] blk_rd_a;
	logic [DATA_W-1:0] blk_rd_b;
	logic [DATA_W-1:0] scr_rd;
	logic [DATA_W-1:0] lift_val;

	always_comb begin
		case (op_s1)
			OP_SUB:  lift_val = blk_rd_b - blk_rd_a;
			OP_ADD:  lift_val = blk_rd_a + blk_rd_b;
			default: lift_val = blk_rd_a;
		endcase
	end

	// load writes and copy-back writes never coincide
	assign blk_we   = accept || copy_s1;
	assign blk_wa   = copy_s1 ? dst_s1 : cnt_q[AW-1:0];
	assign blk_wd   = copy_s1 ? scr_rd : sample;
	assign blk_ra_a = (state_q == S_OUT) ? j_q[AW-1:0] : addr_a[AW-1:0];

	blpt_ram #(
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_block_store (
		.clk  (clk),
		.we   (blk_we),
		.wa   (blk_wa),
		.wd   (blk_wd),
		.ra_a (blk_ra_a),
		.ra_b (addr_b[AW-1:0]),
		.rd_a (blk_rd_a),
		.rd_b (blk_rd_b)
	);

	blpt_ram #(
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_scratch_store (
		.clk  (clk),
		.we   (comp_s1),
		.wa   (dst_s1),
		.wd   (lift_val),
		.ra_a (j_q[AW-1:0]),
		.ra_b (j_q[AW-1:0]),
		.rd_a (scr_rd),
		.rd_b ()
	);

	// results come straight off the block store read port
	assign strobe = out_s1;
	assign value  = blk_rd_a;
	assign last   = last_s1;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_IMP(a_strobe_from_out, strobe, $past(state_q == S_OUT), "strobe without output read")
	`ASSERT_NXT(a_last_ends_block, strobe && last, !strobe, "result after last")
	`ASSERT_IMP(a_pass_min_size, (state_q == S_COMP) || (state_q == S_COPY), n_q >= LEN_W'(2),
		"lifting pass on fewer than two entries")
	`ASSERT_IMP(a_index_in_pass, busy, j_q < n_q, "pass index out of range")

endmodule

// File: sv/blpt_ram.sv
// Byte memory with one write port and two registered read ports.
// Depends on blpt_pkg for the data width.
module blpt_ram
	import blpt_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     wa,
	input  logic [DATA_W-1:0] wd,
	input  logic [AW-1:0]     ra_a,
	input  logic [AW-1:0]     ra_b,
	output logic [DATA_W-1:0] rd_a,
	output logic [DATA_W-1:0] rd_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_a <= mem[ra_a];
		rd_b <= mem[ra_b];
	end

endmodule
